FILE: hdl/sgm_scanline_path_aggregation_unit_macros.svh
// Assertion macros for the scanline path aggregation unit
`ifndef SGM_SCANLINE_PATH_AGGREGATION_UNIT_MACROS_SVH
`define SGM_SCANLINE_PATH_AGGREGATION_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SGM_ASSERT_SAME(lbl, clk_s, rst_ns, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |-> (cons)) \
		else $error("sgm assertion failed");

// Next-cycle implication, disabled while in reset
`define SGM_ASSERT_NEXT(lbl, clk_s, rst_ns, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |=> (cons)) \
		else $error("sgm assertion failed");

`endif

FILE: hdl/sgm_pkg.sv
// Shared types and constants of the scanline path aggregation unit
`timescale 1ns / 1ps
`default_nettype none
package sgm_pkg;

	localparam int PIX_W  = 8;
	localparam int COST_W = 13;
	localparam int P1_W   = 8;
	localparam int P2_W   = 12;
	localparam int MD_W   = 7;
	localparam int IDX_W  = 6;

	localparam logic [COST_W-1:0] COST_MAX = 13'd8191;
	localparam logic [7:0]        COL_MAX  = 8'd255;

	// restoring divider: one quotient bit per cycle
	localparam logic [3:0] DIV_STEPS = 4'd12;

	typedef enum logic [1:0] {
		REG_PENALTY_SMALL = 2'd0,
		REG_PENALTY_LARGE = 2'd1,
		REG_MIN_DISPARITY = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FETCH,
		ST_RUN
	} agg_state_t;

endpackage
`default_nettype wire

FILE: hdl/sgm_ram.sv
// Generic single write port, single read port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module sgm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: hdl/sgm_cell.sv
// One cost cell of the previous-column chain
`timescale 1ns / 1ps
`default_nettype none
module sgm_cell #(
	parameter int WIDTH = 13
) (
	input  wire              clk,
	input  wire              shift,
	input  wire [WIDTH-1:0]  din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] cost_q;

	// take the neighbour's cost on each shift
	always_ff @(posedge clk) begin
		if (shift) begin
			cost_q <= din;
		end
	end

	assign dout = cost_q;

endmodule
`default_nettype wire

FILE: hdl/sgm_div.sv
// Restoring divider for the large-jump penalty over the intensity step
`timescale 1ns / 1ps
`default_nettype none
module sgm_div (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire [sgm_pkg::P2_W-1:0]   dividend,
	input  wire [sgm_pkg::PIX_W-1:0]  divisor,
	output logic                      busy,
	output logic [sgm_pkg::P2_W-1:0]  quotient
);
	import sgm_pkg::*;

	logic             busy_q;
	logic [3:0]       cnt_q;
	logic [PIX_W-1:0] div_q;
	logic [PIX_W-1:0] rem_q;
	logic [P2_W-1:0]  quo_q;
	logic [PIX_W:0]   trial;
	logic             fits;

	// trial subtraction of one step
	always_comb begin
		trial = {rem_q, quo_q[P2_W-1]};
		fits  = trial >= {1'b0, div_q};
	end

	// control: step count and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= divisor != '0;
			cnt_q  <= DIV_STEPS;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 4'd1;
			busy_q <= cnt_q != 4'd1;
		end
	end

	// datapath: shift dividend in, quotient bits out; a zero step keeps the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? PIX_W'(trial - {1'b0, div_q}) : trial[PIX_W-1:0];
			quo_q <= {quo_q[P2_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

FILE: hdl/sgm_scanline_path_aggregation_unit.sv
// Top level: left-to-right SGM path aggregation over one scanline
//
//  channel  | dir | fields
//  ---------+-----+-------------------------------------------------
//  s_*      | in  | tdata: left_pixel, right_pixel; tuser: row_start
//  m_*      | out | tdata: disparity_index, path_cost; tlast: is_last
//  APB      | in  | penalty_small @0, penalty_large @4, min_disparity @8
//
// Each pixel is accepted, passes the bit-serial penalty divider (which does
// not run when the intensity step is zero), primes the history RAM read, then
// yields one word a cycle as the cost chain rotates. Stalls on m_tready hold
// the chain and the RAM address. Reset clears control state only; history and
// costs are undefined until written, so a row must open with row_start.
`timescale 1ns / 1ps
`default_nettype none
module sgm_scanline_path_aggregation_unit #(
	parameter int DISPARITIES   = 64,
	parameter int HISTORY_DEPTH = 128
) (
	input  wire         clk,
	input  wire         arst_n,
	// APB configuration
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// pixel input
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // [7:0] left_pixel, [15:8] right_pixel
	input  wire         s_tuser,   // [0] row_start
	// cost output
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // [5:0] disparity_index, [18:6] path_cost
	output logic        m_tlast
);
	import sgm_pkg::*;

	localparam int DW = (DISPARITIES > 1) ? $clog2(DISPARITIES) : 1;
	localparam int HW = $clog2(HISTORY_DEPTH);
	localparam logic [8:0] HD9 = 9'(HISTORY_DEPTH);
	localparam logic [DW-1:0] DI_LAST = DW'(DISPARITIES - 1);
	localparam logic [HW-1:0] WP_LAST = HW'(HISTORY_DEPTH - 1);
	localparam logic [COST_W:0] BIG = '1;

	// configuration registers
	logic [P1_W-1:0] p1_q;
	logic [P2_W-1:0] p2_q;
	logic [MD_W-1:0] md_q;
	logic            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_q <= 8'd10;
			p2_q <= 12'd120;
			md_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_PENALTY_SMALL: p1_q <= pwdata[P1_W-1:0];
				REG_PENALTY_LARGE: p2_q <= pwdata[P2_W-1:0];
				REG_MIN_DISPARITY: md_q <= pwdata[MD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_PENALTY_SMALL: prdata = {24'd0, p1_q};
			REG_PENALTY_LARGE: prdata = {20'd0, p2_q};
			REG_MIN_DISPARITY: prdata = {25'd0, md_q};
			default:           prdata = '0;
		endcase
	end

	// control and per-item state
	agg_state_t       state_q, state_d;
	logic [DW-1:0]    di_q;
	logic [HW-1:0]    wp_q, wp_nxt;
	logic [7:0]       colcnt_q, col;
	logic [7:0]       col_q;
	logic             start_q;
	logic [PIX_W-1:0] left_q, prev_left_q, rfr_q, gstep;
	logic [COST_W-1:0] prev_min_q, min_q, last_q;
	logic [P2_W-1:0]  far_q, quo;
	logic             div_busy;
	logic             accept, adv;
	logic             out_valid_q, out_last_q;
	logic [COST_W-1:0] out_cost_q;
	logic [DW-1:0]    out_idx_q;

	assign s_tready = state_q == ST_IDLE;
	assign accept   = s_tvalid && s_tready;
	assign adv      = (state_q == ST_RUN) && (!out_valid_q || m_tready);
	assign col      = s_tuser ? 8'd0 : colcnt_q;
	assign gstep    = (s_tdata[7:0] > prev_left_q) ? s_tdata[7:0] - prev_left_q
	                                               : prev_left_q - s_tdata[7:0];
	assign wp_nxt   = (wp_q == WP_LAST) ? '0 : wp_q + HW'(1);

	// penalty divider
	sgm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend (p2_q),
		.divisor  (gstep),
		.busy     (div_busy),
		.quotient (quo)
	);

	// history RAM, newest entry at wp_q
	logic [DW-1:0]    rd_di;
	logic [HW-1:0]    raddr;
	logic [PIX_W-1:0] hist_rd;
	logic [7:0]       rd_d;
	logic [8:0]       rd_k;
	logic [9:0]       rd_diff;

	always_comb begin
		if (state_q == ST_FETCH) begin
			rd_di = '0;
		end else if (adv) begin
			rd_di = di_q + DW'(1);
		end else begin
			rd_di = di_q;
		end
		rd_d    = 8'(rd_di) + 8'(md_q);
		rd_k    = ({1'b0, rd_d} < HD9) ? {1'b0, rd_d} : HD9 - 9'd1;
		rd_diff = {1'b0, 9'(wp_q)} - {1'b0, rd_k};
		if (rd_diff[9]) begin
			rd_diff = rd_diff + {1'b0, HD9};
		end
		raddr = rd_diff[HW-1:0];
	end

	sgm_ram #(
		.WIDTH (PIX_W),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_nxt),
		.wdata (s_tdata[15:8]),
		.raddr (raddr),
		.rdata (hist_rd)
	);

	// chain of previous-column costs, head holds index di_q
	logic [COST_W-1:0] chain [DISPARITIES];
	logic [COST_W-1:0] new_cost;

	for (genvar i = 0; i < DISPARITIES; i++) begin : g_chain
		sgm_cell #(.WIDTH(COST_W)) u_cell (
			.clk   (clk),
			.shift (adv),
			.din   ((i == DISPARITIES - 1) ? new_cost : chain[(i + 1) % DISPARITIES]),
			.dout  (chain[i])
		);
	end

	// cost of the current disparity
	logic [7:0]        cur_d;
	logic [PIX_W-1:0]  rv, raw;
	logic [COST_W:0]   c_same, c_lo, c_hi, c_far, sm;
	logic [COST_W+1:0] sum, net;

	always_comb begin
		cur_d  = 8'(di_q) + 8'(md_q);
		rv     = (col_q <= cur_d) ? rfr_q : hist_rd;
		raw    = (left_q > rv) ? left_q - rv : rv - left_q;
		c_same = {1'b0, chain[0]};
		c_lo   = (di_q != '0) ? {1'b0, last_q} + (COST_W+1)'(p1_q) : BIG;
		c_hi   = (di_q != DI_LAST) ? {1'b0, chain[1 % DISPARITIES]} + (COST_W+1)'(p1_q)
		                           : BIG;
		c_far  = {1'b0, prev_min_q} + (COST_W+1)'(far_q);
		sm     = c_same;
		if (c_lo < sm) sm = c_lo;
		if (c_hi < sm) sm = c_hi;
		if (c_far < sm) sm = c_far;
		sum = {1'b0, sm} + (COST_W+2)'(raw);
		net = (sum >= (COST_W+2)'(prev_min_q)) ? sum - (COST_W+2)'(prev_min_q) : '0;
		if (start_q) begin
			new_cost = COST_W'(raw);
		end else if (net > (COST_W+2)'(COST_MAX)) begin
			new_cost = COST_MAX;
		end else begin
			new_cost = net[COST_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept) state_d = ST_DIV;
			ST_DIV:   if (!div_busy) state_d = ST_FETCH;
			ST_FETCH: state_d = ST_RUN;
			ST_RUN:   if (adv && di_q == DI_LAST) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// row and history bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			colcnt_q    <= '0;
			prev_left_q <= '0;
			rfr_q       <= '0;
			prev_min_q  <= '0;
		end else begin
			if (accept) begin
				wp_q        <= wp_nxt;
				colcnt_q    <= (col < COL_MAX) ? col + 8'd1 : COL_MAX;
				prev_left_q <= s_tdata[7:0];
				if (col == 8'd0) begin
					rfr_q <= s_tdata[15:8];
				end
			end
			if (adv && di_q == DI_LAST) begin
				prev_min_q <= (new_cost < min_q) ? new_cost : min_q;
			end
		end
	end

	// latch the item and step through disparities
	always_ff @(posedge clk) begin
		if (accept) begin
			left_q  <= s_tdata[7:0];
			start_q <= s_tuser;
			col_q   <= col;
		end
		if (state_q == ST_FETCH) begin
			far_q <= (quo > P2_W'(p1_q)) ? quo : P2_W'(p1_q);
			di_q  <= '0;
			min_q <= COST_MAX;
		end else if (adv) begin
			di_q   <= di_q + DW'(1);
			last_q <= chain[0];
			if (new_cost < min_q) begin
				min_q <= new_cost;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_idx_q  <= di_q;
			out_cost_q <= new_cost;
			out_last_q <= di_q == DI_LAST;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_cost_q, IDX_W'(out_idx_q)};
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

FILE: hdl/sgm_checker.sv
// Port-level checks of the aggregation unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "sgm_scanline_path_aggregation_unit_macros.svh"
module sgm_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata,
	input wire        m_tlast
);

	// a stalled word holds
	`SGM_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// busy once a pixel is taken
	`SGM_ASSERT_NEXT(a_busy_after_take, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// disparities come in order
	`SGM_ASSERT_NEXT(a_idx_step, clk, arst_n, m_tvalid && m_tready && !m_tlast, !m_tvalid || m_tdata[5:0] == $past(m_tdata[5:0]) + 6'd1)

	// a new pixel opens at index zero
	`SGM_ASSERT_NEXT(a_idx_wrap, clk, arst_n, m_tvalid && m_tready && m_tlast, !m_tvalid || m_tdata[5:0] == 6'd0)

endmodule

bind sgm_scanline_path_aggregation_unit sgm_checker u_sgm_checker (.*);
`default_nettype wire

FILE: tb/sgm_scanline_path_aggregation_unit_tb.sv
// Self-checking testbench for the scanline path aggregation unit
`timescale 1ns / 1ps
module sgm_scanline_path_aggregation_unit_tb;
	import sgm_pkg::*;

	localparam int NDISP = 64;
	localparam int HDEPTH = 128;

	typedef struct packed {
		logic [PIX_W-1:0]  left;
		logic [PIX_W-1:0]  right;
		logic              start;
		logic              typed;   // costs known at a glance: all equal to flat_cost
		logic [COST_W-1:0] flat_cost;
	} pixel_row_t;

	typedef struct {
		logic [IDX_W-1:0]  idx;
		logic [COST_W-1:0] cost;
		logic              last;
	} cost_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;

	sgm_scanline_path_aggregation_unit dut (.*);

	// predictor state
	int unsigned pen_small = 10, pen_large = 120, min_disp = 0;
	logic [7:0]  right_hist [HDEPTH];
	int unsigned prev_costs [NDISP];
	int unsigned prev_min = 0, prev_left = 0, first_right = 0, col_count = 0;

	cost_word_t  cost_queue [$];
	int          errors = 0;
	int          pixels_sent = 0, words_seen = 0;
	bit          quiet = 1'b0;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// work out the cost words of one accepted pixel and advance the path state
	function automatic void aggregate_pixel(logic [7:0] l, logic [7:0] r, logic st,
			logic typed, logic [12:0] flat);
		int unsigned col, g, q, far_pen, d, rv, raw, sm, c, cost, newmin;
		int unsigned newc [NDISP];
		cost_word_t w;
		col = st ? 0 : col_count;
		if (col == 0) first_right = r;
		for (int k = HDEPTH - 1; k > 0; k--) right_hist[k] = right_hist[k-1];
		right_hist[0] = r;
		g = (l > prev_left) ? l - prev_left : prev_left - l;
		q = (g > 0) ? pen_large / g : pen_large;
		far_pen = (q > pen_small) ? q : pen_small;
		newmin = COST_MAX;
		for (int di = 0; di < NDISP; di++) begin
			d = di + min_disp;
			rv = (col <= d) ? first_right : right_hist[(d < HDEPTH) ? d : HDEPTH - 1];
			raw = (l > rv) ? l - rv : rv - l;
			if (st) begin
				cost = raw;
			end else begin
				sm = 32'hFFFF_FFFF;
				for (int dp = 0; dp < NDISP; dp++) begin
					c = prev_costs[dp];
					if (dp == di) c = c;
					else if (dp == di + 1 || dp + 1 == di) c = c + pen_small;
					else c = c + far_pen;
					if (c < sm) sm = c;
				end
				cost = raw + sm;
				cost = (cost >= prev_min) ? cost - prev_min : 0;
			end
			if (cost > COST_MAX) cost = COST_MAX;
			newc[di] = cost;
			if (cost < newmin) newmin = cost;
			w.idx = IDX_W'(di);
			w.cost = typed ? flat : cost[12:0];
			w.last = (di == NDISP - 1);
			cost_queue.insert(cost_queue.size(), w);
		end
		prev_costs = newc;
		prev_min = newmin;
		prev_left = l;
		col_count = (col < 255) ? col + 1 : 255;
	endfunction

	// present one pixel and hold it until accepted
	task automatic send_pixel(logic [7:0] l, logic [7:0] r, logic st,
			logic typed = 1'b0, logic [12:0] flat = '0);
		while (!quiet && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {r, l};
		s_tuser <= st;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		aggregate_pixel(l, r, st, typed, flat);
		pixels_sent++;
		@(negedge clk);
	endtask

	// hold off until every cost word has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (cost_queue.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic cfg_write(reg_idx_t r, int unsigned v);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= 4'(r) << 2; pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (r)
			REG_PENALTY_SMALL: pen_small = v & 8'hFF;
			REG_PENALTY_LARGE: pen_large = v & 12'hFFF;
			default:           min_disp = v & 7'h7F;
		endcase
	endtask

	task automatic random_rows(int n_items, int max_len);
		int len;
		while (n_items > 0) begin
			len = $urandom_range(max_len, 1);
			for (int k = 0; k < len && n_items > 0; k++, n_items--) begin
				// left intensities are sometimes coarsened to multiples of 16, otherwise random
				if ($urandom_range(3) == 0)
					send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), k == 0);
				else
					send_pixel(8'($urandom_range(255) & (($urandom_range(1)) ? 8'hFF : 8'hF0)),
						8'($urandom_range(255)), k == 0);
			end
		end
	endtask

	// receiver: random back-pressure
	initial begin
		forever begin
			@(negedge clk);
			m_tready <= quiet || ($urandom_range(99) >= 6);
		end
	end

	// check each cost word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			words_seen++;
			if (cost_queue.size() == 0) begin
				$display("%0t: unexpected word idx=%0d cost=%0d last=%0b", $time,
					m_tdata[5:0], m_tdata[18:6], m_tlast);
				errors++;
			end else begin
				cost_word_t w;
				w = cost_queue.pop_front();
				if (m_tdata[5:0] !== w.idx) begin
					$display("%0t: index expected %0d actual %0d", $time, w.idx, m_tdata[5:0]);
					errors++;
				end
				if (m_tdata[18:6] !== w.cost) begin
					$display("%0t: cost at %0d expected %0d actual %0d", $time, w.idx,
						w.cost, m_tdata[18:6]);
					errors++;
				end
				if (m_tlast !== w.last) begin
					$display("%0t: last at %0d expected %0b actual %0b", $time, w.idx,
						w.last, m_tlast);
					errors++;
				end
			end
		end
	end

	pixel_row_t directed [20] = '{
		'{8'd0,   8'd255, 1'b1, 1'b1, 13'd255},
		'{8'd255, 8'd0,   1'b1, 1'b1, 13'd255},
		'{8'd255, 8'd255, 1'b1, 1'b1, 13'd0},
		'{8'd0,   8'd0,   1'b1, 1'b1, 13'd0},
		'{8'd128, 8'd37,  1'b1, 1'b1, 13'd91},
		'{8'd128, 8'd200, 1'b0, 1'b0, 13'd0},
		'{8'd128, 8'd0,   1'b0, 1'b0, 13'd0},
		'{8'd0,   8'd255, 1'b0, 1'b0, 13'd0},
		'{8'd255, 8'd1,   1'b0, 1'b0, 13'd0},
		'{8'd1,   8'd254, 1'b0, 1'b0, 13'd0},
		'{8'd170, 8'd85,  1'b0, 1'b0, 13'd0},
		'{8'd85,  8'd170, 1'b0, 1'b0, 13'd0},
		'{8'd86,  8'd171, 1'b0, 1'b0, 13'd0},
		'{8'd200, 8'd15,  1'b1, 1'b1, 13'd185},
		'{8'd201, 8'd240, 1'b0, 1'b0, 13'd0},
		'{8'd60,  8'd3,   1'b0, 1'b0, 13'd0},
		'{8'd61,  8'd128, 1'b0, 1'b0, 13'd0},
		'{8'd255, 8'd255, 1'b0, 1'b0, 13'd0},
		'{8'd0,   8'd0,   1'b0, 1'b0, 13'd0},
		'{8'd15,  8'd240, 1'b0, 1'b0, 13'd0}
	};

	initial begin
		for (int k = 0; k < HDEPTH; k++) right_hist[k] = '0;
		for (int k = 0; k < NDISP; k++) prev_costs[k] = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed rows at reset penalties
		foreach (directed[i])
			send_pixel(directed[i].left, directed[i].right, directed[i].start,
				directed[i].typed, directed[i].flat_cost);
		drain();

		// no penalties at all
		cfg_write(REG_PENALTY_SMALL, 0);
		cfg_write(REG_PENALTY_LARGE, 0);
		cfg_write(REG_MIN_DISPARITY, 0);
		random_rows(40, 20);
		drain();

		// heaviest penalties, offset 64; run with no idling on either side
		cfg_write(REG_PENALTY_SMALL, 255);
		cfg_write(REG_PENALTY_LARGE, 4095);
		cfg_write(REG_MIN_DISPARITY, 64);
		quiet = 1'b1;
		random_rows(40, 80);
		quiet = 1'b0;
		drain();

		// mid-range penalties, small offset
		cfg_write(REG_PENALTY_SMALL, $urandom_range(254, 1));
		cfg_write(REG_PENALTY_LARGE, $urandom_range(4094, 1));
		cfg_write(REG_MIN_DISPARITY, $urandom_range(63, 1));
		random_rows(30, 12);
		drain();

		// largest offset: one long row past the history depth
		cfg_write(REG_MIN_DISPARITY, 127);
		cfg_write(REG_PENALTY_LARGE, $urandom_range(4095));
		for (int k = 0; k < 180; k++)
			send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), k == 0);
		drain();

		repeat (100) @(negedge clk);
		$display("Covered %0d pixels and %0d cost words over five penalty and offset settings,",
			pixels_sent, words_seen);
		$display("including row starts, intensity extremes and lookback past the history.");
		if (errors == 0 && cost_queue.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
